/* design/aip_pkg.sv */
// Package with shared types and constants of the ASCII integer parser.
`timescale 1ns / 1ps

package aip_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_LEN    = 255;
  localparam int POS_W      = $clog2(MAX_LEN + 1);
  localparam int CH_W       = 8;
  localparam int BASE_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BASE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'd1;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } item_t;

endpackage

/* design/aip_if.sv */
// Channel interfaces: character input, result output and register writes.
`timescale 1ns / 1ps

interface aip_in_if;
  logic                       valid;
  logic                       ready;
  logic [aip_pkg::CH_W-1:0]   ch;
  logic                       last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface aip_out_if;
  logic                           valid;
  logic                           ready;
  logic [aip_pkg::VALUE_BITS-1:0] value;
  logic [aip_pkg::POS_W-1:0]      end_index;
  logic                           any_digits;
  modport source (output valid, value, end_index, any_digits, input ready);
  modport sink   (input valid, value, end_index, any_digits, output ready);
endinterface

interface aip_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aip_pkg::CFG_IDX_W-1:0]  index;
  logic [aip_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/aip_cfg_regs.sv */
// Configuration registers: number base and signed mode.
`timescale 1ns / 1ps

module aip_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  aip_cfg_if.sink       cfg_i,
  output aip_pkg::cfg_t cfg_o
);

  aip_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.number_base <= '0;
      cfg_q.signed_mode <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        aip_pkg::CFG_NUMBER_BASE: cfg_q.number_base <= cfg_i.data;
        aip_pkg::CFG_SIGNED_MODE: cfg_q.signed_mode <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

/* design/aip_in_stage.sv */
// Input register for incoming characters.
`timescale 1ns / 1ps

module aip_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  aip_in_if.sink         in_i,
  output logic           valid_o,
  output aip_pkg::item_t item_o,
  input  logic           ready_i
);

  logic           valid_q;
  aip_pkg::item_t item_q;
  logic           in_fire;

  assign in_i.ready = !valid_q || ready_i;
  assign in_fire    = in_i.valid && in_i.ready;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_fire) begin
      valid_q     <= 1'b1;
      item_q.ch   <= in_i.ch;
      item_q.last <= in_i.last;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

/* design/aip_parser.sv */
// Parse state machine, digit accumulation and result register.
`timescale 1ns / 1ps

module aip_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aip_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  aip_pkg::item_t item_i,
  output logic           item_ready_o,
  aip_out_if.source      out_o
);

  localparam int VB = aip_pkg::VALUE_BITS;
  localparam int PW = aip_pkg::POS_W;
  localparam int BW = aip_pkg::BASE_W;
  localparam int CW = aip_pkg::CH_W;

  localparam logic [CW-1:0] CH_NUL   = 8'h00;
  localparam logic [CW-1:0] CH_TAB   = 8'h09;
  localparam logic [CW-1:0] CH_LF    = 8'h0A;
  localparam logic [CW-1:0] CH_VT    = 8'h0B;
  localparam logic [CW-1:0] CH_FF    = 8'h0C;
  localparam logic [CW-1:0] CH_CR    = 8'h0D;
  localparam logic [CW-1:0] CH_SPACE = 8'h20;
  localparam logic [CW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CW-1:0] CH_NINE  = 8'h39;
  localparam logic [CW-1:0] CH_A_UP  = 8'h41;
  localparam logic [CW-1:0] CH_X_UP  = 8'h58;
  localparam logic [CW-1:0] CH_Z_UP  = 8'h5A;
  localparam logic [CW-1:0] CH_A_LO  = 8'h61;
  localparam logic [CW-1:0] CH_X_LO  = 8'h78;
  localparam logic [CW-1:0] CH_Z_LO  = 8'h7A;
  localparam logic [CW-1:0] DIG_NONE = 8'hFF;
  localparam logic [CW-1:0] DIG_TEN  = 8'd10;

  localparam logic [BW-1:0] BASE_AUTO = 6'd0;
  localparam logic [BW-1:0] BASE_OCT  = 6'd8;
  localparam logic [BW-1:0] BASE_DEC  = 6'd10;
  localparam logic [BW-1:0] BASE_HEX  = 6'd16;

  localparam logic [PW-1:0] POS_MAX = PW'(aip_pkg::MAX_LEN);

  typedef enum logic [2:0] {
    PH_WS1,
    PH_WS2,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  function automatic logic is_blank(input logic [CW-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic logic [CW-1:0] digit_value(input logic [CW-1:0] c);
    logic [CW-1:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
      v = c - CH_A_LO + DIG_TEN;
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      v = c - CH_A_UP + DIG_TEN;
    end else begin
      v = DIG_NONE;
    end
    return v;
  endfunction

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] p);
    return (p >= POS_MAX) ? POS_MAX : p + 1'b1;
  endfunction

  phase_e          phase_q, phase_d;
  logic [VB-1:0]   acc_q, acc_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   stop_q, stop_d;
  logic            neg_q, neg_d;
  logic [BW-1:0]   base_q, base_d;
  logic            seen_q, seen_d;

  logic            out_valid_q;
  logic [VB-1:0]   value_q, value_d;
  logic [PW-1:0]   end_index_q, end_index_d;
  logic            any_digits_q;

  logic            fire;

  assign item_ready_o     = !item_i.last || !out_valid_q || out_o.ready;
  assign fire             = item_valid_i && item_ready_o;
  assign out_o.valid      = out_valid_q;
  assign out_o.value      = value_q;
  assign out_o.end_index  = end_index_q;
  assign out_o.any_digits = any_digits_q;

  always_comb begin : next_state
    logic          take;
    logic [CW-1:0] c;
    logic [CW-1:0] dv;
    logic [VB-1:0] prod;

    c       = item_i.ch;
    take    = 1'b1;
    phase_d = phase_q;
    acc_d   = acc_q;
    stop_d  = stop_q;
    neg_d   = neg_q;
    base_d  = base_q;
    seen_d  = seen_q;
    dv      = digit_value(c);
    prod    = acc_q * {{(VB-BW){1'b0}}, base_q};

    if (phase_d == PH_WS1) begin
      if (is_blank(c)) begin
        take = 1'b0;
      end else if (cfg_i.signed_mode && c == CH_MINUS) begin
        neg_d   = 1'b1;
        phase_d = PH_WS2;
        take    = 1'b0;
      end else if (c == CH_PLUS) begin
        phase_d = cfg_i.signed_mode ? PH_WS2 : PH_PREFIX;
        take    = 1'b0;
      end else begin
        phase_d = PH_PREFIX;
      end
    end
    if (take && phase_d == PH_WS2) begin
      if (is_blank(c)) begin
        take = 1'b0;
      end else if (c == CH_PLUS) begin
        phase_d = PH_PREFIX;
        take    = 1'b0;
      end else begin
        phase_d = PH_PREFIX;
      end
    end
    if (take && phase_d == PH_PREFIX) begin
      if ((cfg_i.number_base == BASE_AUTO || cfg_i.number_base == BASE_HEX) &&
          c == CH_ZERO) begin
        base_d  = cfg_i.number_base;
        phase_d = PH_ZERO;
        take    = 1'b0;
      end else begin
        base_d  = (cfg_i.number_base == BASE_AUTO) ? BASE_DEC : cfg_i.number_base;
        phase_d = PH_DIGITS;
      end
    end
    if (take && phase_d == PH_ZERO) begin
      if (c == CH_X_LO || c == CH_X_UP) begin
        base_d  = BASE_HEX;
        phase_d = PH_DIGITS;
        take    = 1'b0;
      end else begin
        if (base_d == BASE_HEX) begin
          seen_d = 1'b1;
          stop_d = pos_q;
        end else begin
          base_d = BASE_OCT;
        end
        phase_d = PH_DIGITS;
      end
    end
    if (take && phase_d == PH_DIGITS) begin
      if (c == CH_NUL || dv >= {{(CW-BW){1'b0}}, base_d}) begin
        phase_d = PH_DONE;
      end else begin
        acc_d  = prod + {{(VB-BW){1'b0}}, dv[BW-1:0]};
        seen_d = 1'b1;
        stop_d = sat_inc(pos_q);
      end
    end

    pos_d = sat_inc(pos_q);

    if (phase_d == PH_ZERO && base_d == BASE_HEX) begin
      end_index_d = pos_d;
    end else begin
      end_index_d = seen_d ? stop_d : '0;
    end
    value_d = neg_d ? (~acc_d + 1'b1) : acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS1;
      acc_q       <= '0;
      pos_q       <= '0;
      stop_q      <= '0;
      neg_q       <= 1'b0;
      base_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        if (item_i.last) begin
          value_q      <= value_d;
          end_index_q  <= end_index_d;
          any_digits_q <= seen_d || (phase_d == PH_ZERO && base_d == BASE_HEX);
          phase_q      <= PH_WS1;
          acc_q        <= '0;
          pos_q        <= '0;
          stop_q       <= '0;
          neg_q        <= 1'b0;
          base_q       <= '0;
          seen_q       <= 1'b0;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          pos_q   <= pos_d;
          stop_q  <= stop_d;
          neg_q   <= neg_d;
          base_q  <= base_d;
          seen_q  <= seen_d;
        end
      end
    end
  end

endmodule

/* design/ascii_integer_parser_core.sv */
// Top level of the streaming ASCII-to-integer parser.
`timescale 1ns / 1ps

// Takes one character per transfer and returns one result (value, end_index,
// any_digits) for each string, after the character marked last. Throughput is one
// character per clock while no last character is held; a character passes an input
// register and then the parse step, a single multiply-add of the 32-bit accumulator
// by the 6-bit base, which writes the result register, where the result of a string
// is offered once its last character has passed the parse step. A last character
// waits in the input register while the previous result has not yet transferred,
// which holds the input. Write number_base (index 0) and signed_mode (index 1) only
// between strings.
module ascii_integer_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  aip_cfg_if.sink    cfg_i,
  aip_in_if.sink     in_i,
  aip_out_if.source  out_o
);

  aip_pkg::cfg_t  cfg;
  logic           stage_valid;
  logic           stage_ready;
  aip_pkg::item_t stage_item;

  aip_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  aip_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (stage_valid),
    .item_o  (stage_item),
    .ready_i (stage_ready)
  );

  aip_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .item_ready_o (stage_ready),
    .out_o        (out_o)
  );

  a_no_digits_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.any_digits |-> out_o.end_index == '0)
    else $error("end index set without digits");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(stage_valid && stage_ready && stage_item.last))
    else $error("result without a last character");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !stage_ready |=> stage_valid && $stable(stage_item))
    else $error("input register lost a stalled character");

endmodule

/* tb/ascii_integer_parser_core_test.sv */
// Self-checking testbench for the streaming ASCII integer parser core.
`timescale 1ns / 1ps

module ascii_integer_parser_core_test;
  import aip_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 80;
  localparam int RANDOM_ITEMS    = 600;
  localparam int PHASE_ITEMS     = 40;
  localparam int SCRIPT_LEN      = 26;

  typedef enum logic [2:0] {
    LEAD_BLANK, POST_SIGN, RADIX, ZERO_SEEN, DIGITS, STOPPED
  } parse_phase_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [POS_W-1:0]      end_index;
    logic                  any_digits;
  } result_t;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic            lst;
    logic            typed;
    result_t         res;
  } step_t;

  localparam result_t NO_DIGITS = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aip_in_if  in_if ();
  aip_out_if out_if ();
  aip_cfg_if cfg_if ();

  ascii_integer_parser_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register shadows and parse state of the predictor
  logic [BASE_W-1:0]     base_reg = '0;
  logic                  sign_mode_reg = 1'b1;
  parse_phase_e          ps = LEAD_BLANK;
  logic [VALUE_BITS-1:0] acc = '0;
  logic [POS_W-1:0]      pos = '0;
  logic [POS_W-1:0]      stop_pos = '0;
  logic                  neg = 1'b0;
  logic [BASE_W-1:0]     eff_base = '0;
  logic                  got_digit = 1'b0;

  result_t pending_results[$];
  int      mismatches = 0;
  int      accepted = 0;
  int      gap_max = 5;
  int      stall_max = 5;
  logic    hold_req = 1'b0;
  int      quiet = 0;

  step_t script [SCRIPT_LEN] = '{
    '{"0", 1'b1, 1'b1, NO_DIGITS},
    '{"-", 1'b0, 1'b0, NO_DIGITS},
    '{"1", 1'b0, 1'b0, NO_DIGITS},
    '{"2", 1'b1, 1'b0, NO_DIGITS},
    '{"0", 1'b0, 1'b0, NO_DIGITS},
    '{"x", 1'b1, 1'b1, NO_DIGITS},
    '{"0", 1'b0, 1'b0, NO_DIGITS},
    '{"x", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b0, 1'b0, NO_DIGITS},
    '{"F", 1'b1, 1'b1, '{32'hFFFF_FFFF, 8'd10, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, NO_DIGITS},
    '{"0", 1'b0, 1'b0, NO_DIGITS},
    '{"1", 1'b0, 1'b0, NO_DIGITS},
    '{"7", 1'b0, 1'b0, NO_DIGITS},
    '{8'h00, 1'b0, 1'b0, NO_DIGITS},
    '{"9", 1'b1, 1'b0, NO_DIGITS},
    '{"+", 1'b0, 1'b0, NO_DIGITS},
    '{" ", 1'b0, 1'b0, NO_DIGITS},
    '{"+", 1'b0, 1'b0, NO_DIGITS},
    '{"5", 1'b1, 1'b0, NO_DIGITS}
  };

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C || c == 8'h0B;
  endfunction

  function automatic logic [POS_W-1:0] sat_step(input logic [POS_W-1:0] p);
    return (p >= MAX_LEN) ? POS_W'(MAX_LEN) : p + 1'b1;
  endfunction

  function automatic logic [CH_W-1:0] pick_blank();
    logic [CH_W-1:0] blanks [6];
    blanks = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};
    return blanks[$urandom_range(0, 5)];
  endfunction

  function automatic logic [CH_W-1:0] digit_char(input int radix);
    int v;
    v = $urandom_range(0, radix - 1);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  // Advance the parse by one character; return 1 with the result on the final one
  function automatic logic parse_char(input logic [CH_W-1:0] c, input logic lst,
                                      output result_t r);
    logic [POS_W-1:0] here;
    logic             consume;
    logic [7:0]       dv;
    here = pos;
    consume = 1'b1;
    r = NO_DIGITS;
    if (ps == LEAD_BLANK) begin
      if (is_blank(c)) begin
        consume = 1'b0;
      end else if (sign_mode_reg && c == "-") begin
        neg = 1'b1;
        ps = POST_SIGN;
        consume = 1'b0;
      end else if (c == "+") begin
        ps = sign_mode_reg ? POST_SIGN : RADIX;
        consume = 1'b0;
      end else begin
        ps = RADIX;
      end
    end
    if (consume && ps == POST_SIGN) begin
      if (is_blank(c)) begin
        consume = 1'b0;
      end else if (c == "+") begin
        ps = RADIX;
        consume = 1'b0;
      end else begin
        ps = RADIX;
      end
    end
    if (consume && ps == RADIX) begin
      if ((base_reg == 0 || base_reg == 16) && c == "0") begin
        eff_base = base_reg;
        ps = ZERO_SEEN;
        consume = 1'b0;
      end else begin
        eff_base = (base_reg == 0) ? BASE_W'(10) : base_reg;
        ps = DIGITS;
      end
    end
    if (consume && ps == ZERO_SEEN) begin
      if (c == "x" || c == "X") begin
        eff_base = BASE_W'(16);
        ps = DIGITS;
        consume = 1'b0;
      end else begin
        if (eff_base == 16) begin
          got_digit = 1'b1;
          stop_pos = here;
        end else begin
          eff_base = BASE_W'(8);
        end
        ps = DIGITS;
      end
    end
    if (consume && ps == DIGITS) begin
      if (c >= "0" && c <= "9") dv = c - "0";
      else if (c >= "a" && c <= "z") dv = c - "a" + 8'd10;
      else if (c >= "A" && c <= "Z") dv = c - "A" + 8'd10;
      else dv = 8'd255;
      if (c == 8'h00 || dv >= eff_base) begin
        ps = STOPPED;
      end else begin
        acc = acc * VALUE_BITS'(eff_base) + VALUE_BITS'(dv);
        got_digit = 1'b1;
        stop_pos = sat_step(here);
      end
    end
    pos = sat_step(here);
    if (!lst) return 1'b0;
    if (ps == ZERO_SEEN && eff_base == 16) begin
      got_digit = 1'b1;
      stop_pos = pos;
    end
    r.value = neg ? -acc : acc;
    r.end_index = got_digit ? stop_pos : '0;
    r.any_digits = got_digit;
    ps = LEAD_BLANK;
    acc = '0;
    pos = '0;
    stop_pos = '0;
    neg = 1'b0;
    eff_base = '0;
    got_digit = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [CH_W-1:0] c, input logic lst, input logic typed,
                           input result_t typed_res);
    int      gap;
    result_t r;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= lst;
    do @(posedge clk); while (!in_if.ready);
    accepted++;
    if (parse_char(c, lst, r)) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_NUMBER_BASE) base_reg = val;
    else sign_mode_reg = val[0];
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : results_sink
    int      n;
    result_t got;
    result_t want;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = '{out_if.value, out_if.end_index, out_if.any_digits};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, actual value %h end_index %0d any_digits %b",
                 $time, got.value, got.end_index, got.any_digits);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          mismatches++;
        end
        if (got.end_index !== want.end_index) begin
          $display("%0t: end_index expected %0d actual %0d", $time, want.end_index,
                   got.end_index);
          mismatches++;
        end
        if (got.any_digits !== want.any_digits) begin
          $display("%0t: any_digits expected %b actual %b", $time, want.any_digits,
                   got.any_digits);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BASE_W-1:0] plan_base [8];
    logic              plan_sign [8];
    logic [CH_W-1:0]   chars[$];
    logic [BASE_W-1:0] next_base;
    logic              next_sign;
    logic              long_sent;
    logic              paused;
    int                p;
    int                phase_items;
    int                sel;
    int                db;
    plan_base = '{6'd10, 6'd16, 6'd0, 6'd2, 6'd36, 6'd1, 6'd63, 6'd8};
    plan_sign = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    long_sent = 1'b0;
    in_if.valid  <= 1'b0;
    in_if.ch     <= '0;
    in_if.last   <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_char(script[i].ch, script[i].lst, script[i].typed, script[i].res);
    settle();

    accepted = 0;
    p = 0;
    while (accepted < RANDOM_ITEMS) begin
      if (p < 8) begin
        next_base = plan_base[p];
        next_sign = plan_sign[p];
      end else begin
        next_base = ($urandom_range(0, 4) == 0) ? BASE_W'($urandom_range(0, 63))
                                                : BASE_W'($urandom_range(0, 36));
        next_sign = 1'($urandom_range(0, 1));
      end
      write_reg(CFG_NUMBER_BASE, next_base);
      write_reg(CFG_SIGNED_MODE, {CFG_DATA_W'($urandom_range(0, 31)) << 1} | next_sign);
      cfg_if.valid <= 1'b0;
      gap_max   = (p % 4 == 1) ? 0 : 5;
      stall_max = (p % 4 == 1 || p % 4 == 3) ? 0 : 5;
      if (p == 1) hold_req = 1'b1;
      paused = 1'b0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        chars = {};
        if (base_reg == 10 && !long_sent) begin
          long_sent = 1'b1;
          repeat (270) chars.push_back(digit_char(10));
        end else if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) chars.push_back(CH_W'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(0, 2)) chars.push_back(pick_blank());
          sel = $urandom_range(0, 3);
          if (sel == 1 || (sel == 3 && sign_mode_reg)) chars.push_back("-");
          else if (sel != 0) chars.push_back("+");
          if (sel != 0 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 1)) chars.push_back(pick_blank());
            if ($urandom_range(0, 1) == 1) chars.push_back("+");
          end
          db = (base_reg > 36) ? 36 : base_reg;
          sel = $urandom_range(0, 2);
          if (base_reg == 0) begin
            if (sel == 0) begin
              chars.push_back("0");
              chars.push_back($urandom_range(0, 1) ? "x" : "X");
              db = 16;
            end else if (sel == 1) begin
              chars.push_back("0");
              db = 8;
            end else begin
              chars.push_back(CH_W'("0" + $urandom_range(1, 9)));
              db = 10;
            end
          end else if (base_reg == 16 && sel == 0) begin
            chars.push_back("0");
            chars.push_back($urandom_range(0, 1) ? "x" : "X");
          end
          repeat ($urandom_range(0, 11)) chars.push_back(digit_char(db));
          sel = $urandom_range(0, 3);
          if (sel == 1) chars.push_back(8'h00);
          else if (sel == 2) chars.push_back(CH_W'($urandom_range(0, 255)));
          if (sel != 0)
            repeat ($urandom_range(0, 3)) chars.push_back(CH_W'($urandom_range(0, 255)));
        end
        if (chars.size() == 0) chars.push_back("0");
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, 1'b0, NO_DIGITS);
        phase_items += chars.size();
        if (p == 3 && !paused && phase_items >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          in_if.valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      settle();
      p++;
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
